### hw/rtl/pnn_pkg.sv
`default_nettype none
package pnn_pkg;
  localparam int COORD_BITS = 24;
  localparam int SUM_BITS   = 58;
  localparam int OUT_BITS   = 16;
  localparam int OUT_ONE    = 16384;
  localparam logic signed [SUM_BITS-1:0] SUM_LIM = {1'b0, {(SUM_BITS-1){1'b1}}};

  // commands from controller to datapath
  typedef struct packed {
    logic load_vtx;   // latch input vertex, form pair operands
    logic start_vtx;  // vertex opens a polygon
    logic acc_pair;   // multiply/accumulate current pair (registered operands)
    logic sel_close;  // operands are (previous, first)
    logic norm_start; // start normalization
  } pnn_cmd_t;

  typedef struct packed {
    logic norm_done;
  } pnn_sts_t;

  function automatic logic signed [SUM_BITS-1:0] sat_add(
      input logic signed [SUM_BITS-1:0] s, input logic signed [SUM_BITS-1:0] t);
    logic signed [SUM_BITS:0] r;
    r = {s[SUM_BITS-1], s} + {t[SUM_BITS-1], t};
    if (r > $signed({1'b0, SUM_LIM})) return SUM_LIM;
    if (r < -$signed({1'b0, SUM_LIM})) return -SUM_LIM;
    return r[SUM_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

### hw/rtl/pnn_ctrl.sv
`default_nettype none
module pnn_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_fire,
  input  wire logic           in_last,
  input  wire logic           out_busy,
  input  wire pnn_pkg::pnn_sts_t sts,
  output logic                in_ready,
  output pnn_pkg::pnn_cmd_t   cmd,
  output logic                res_load
);
  import pnn_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_ACC, S_CLOSE, S_NORM, S_OUT} state_t;
  state_t state;
  logic   in_poly, last_q;

  assign in_ready = (state == S_IDLE);

  // vertex is captured on the accepting edge; pair math runs in S_ACC,
  // closing pair in S_CLOSE, which also kicks off normalization
  always_comb begin
    cmd            = '0;
    cmd.load_vtx   = in_fire;
    cmd.start_vtx  = !in_poly;
    cmd.acc_pair   = (state == S_ACC) || (state == S_CLOSE);
    cmd.sel_close  = (state == S_CLOSE);
    cmd.norm_start = (state == S_CLOSE);
  end

  assign res_load = (state == S_OUT) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; in_poly <= 1'b0; last_q <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          last_q  <= in_last;
          in_poly <= !in_last;
          state   <= S_ACC;
        end
        S_ACC: begin
          if (last_q) state <= S_CLOSE;
          else state <= S_IDLE;
        end
        S_CLOSE: state <= S_NORM;
        S_NORM: if (sts.norm_done) state <= S_OUT;
        S_OUT: if (!out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/pnn_dp.sv
`default_nettype none
module pnn_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire pnn_pkg::pnn_cmd_t cmd,
  input  wire logic signed [pnn_pkg::COORD_BITS-1:0] in_x,
  input  wire logic signed [pnn_pkg::COORD_BITS-1:0] in_y,
  input  wire logic signed [pnn_pkg::COORD_BITS-1:0] in_z,
  output pnn_pkg::pnn_sts_t sts,
  output logic signed [pnn_pkg::OUT_BITS-1:0] nx,
  output logic signed [pnn_pkg::OUT_BITS-1:0] ny,
  output logic signed [pnn_pkg::OUT_BITS-1:0] nz,
  output logic degen
);
  import pnn_pkg::*;
  localparam int DB = COORD_BITS + 1;
  localparam int PB = 2 * DB;

  logic signed [COORD_BITS-1:0] fx, fy, fz, px, py, pz, vx, vy, vz;
  logic signed [SUM_BITS-1:0]   sx, sy, sz;
  logic                         start_q;

  // pair operands: a = previous, b = current (or first on closing pair)
  logic signed [COORD_BITS-1:0] bx, by, bz;
  logic signed [DB-1:0] d0, d1, d2, e0, e1, e2;
  logic signed [PB-1:0] p0, p1, p2;
  logic                 pvalid;
  logic                 open_poly;

  always_comb begin
    bx = cmd.sel_close ? fx : vx;
    by = cmd.sel_close ? fy : vy;
    bz = cmd.sel_close ? fz : vz;
  end

  assign d0 = $signed({py[COORD_BITS-1], py}) - $signed({by[COORD_BITS-1], by});
  assign e0 = $signed({pz[COORD_BITS-1], pz}) + $signed({bz[COORD_BITS-1], bz});
  assign d1 = $signed({pz[COORD_BITS-1], pz}) - $signed({bz[COORD_BITS-1], bz});
  assign e1 = $signed({px[COORD_BITS-1], px}) + $signed({bx[COORD_BITS-1], bx});
  assign d2 = $signed({px[COORD_BITS-1], px}) - $signed({bx[COORD_BITS-1], bx});
  assign e2 = $signed({py[COORD_BITS-1], py}) + $signed({by[COORD_BITS-1], by});

  assign open_poly = cmd.acc_pair && start_q;

  // step 1: products of the pair (registered), step 2: accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      fx <= '0; fy <= '0; fz <= '0; px <= '0; py <= '0; pz <= '0;
      vx <= '0; vy <= '0; vz <= '0;
      sx <= '0; sy <= '0; sz <= '0; start_q <= 1'b0;
      p0 <= '0; p1 <= '0; p2 <= '0; pvalid <= 1'b0;
    end else begin
      pvalid <= 1'b0;
      if (cmd.load_vtx) begin
        vx <= in_x; vy <= in_y; vz <= in_z; start_q <= cmd.start_vtx;
      end
      if (cmd.acc_pair) begin
        if (start_q) begin
          fx <= vx; fy <= vy; fz <= vz; px <= vx; py <= vy; pz <= vz;
          start_q <= 1'b0;
        end else begin
          p0 <= d0 * e0;
          p1 <= d1 * e1;
          p2 <= d2 * e2;
          pvalid <= 1'b1;
          if (!cmd.sel_close) begin
            px <= vx; py <= vy; pz <= vz;
          end
        end
      end
      if (open_poly) begin
        sx <= '0; sy <= '0; sz <= '0;
      end else if (pvalid) begin
        sx <= sat_add(sx, SUM_BITS'(p0));
        sy <= sat_add(sy, SUM_BITS'(p1));
        sz <= sat_add(sz, SUM_BITS'(p2));
      end
    end
  end

  // normalization sequencer
  typedef enum logic [3:0] {N_IDLE, N_CWAIT, N_ABS, N_SHIFT, N_SQ0, N_SQ1, N_SQ2,
                            N_SQRT, N_DIV, N_DONE} nst_t;
  nst_t ns;
  logic [SUM_BITS-1:0] ax, ay, az;
  logic [63:0] l2, res, bitv;
  logic [31:0] len;
  logic [1:0]  di;
  logic [5:0]  qc;
  logic [46:0] num, q;
  logic [47:0] r;
  logic        negx, negy, negz;
  logic [SUM_BITS-1:0] amax;
  logic [SUM_BITS-1:0] dval;
  logic [OUT_BITS-1:0] qm;
  logic [31:0] sq_in;
  logic [63:0] sq;

  always_comb begin
    amax = ax;
    if (ay > amax) amax = ay;
    if (az > amax) amax = az;
    unique case (di)
      2'd0: dval = ax;
      2'd1: dval = ay;
      default: dval = az;
    endcase
  end

  // one shared 32x32 squarer
  always_comb begin
    if (ns == N_SQ0) sq_in = ax[31:0];
    else if (ns == N_SQ1) sq_in = ay[31:0];
    else sq_in = az[31:0];
  end
  assign sq = sq_in * sq_in;

  always_comb qm = (q > 47'(OUT_ONE)) ? OUT_BITS'(OUT_ONE) : q[OUT_BITS-1:0];

  logic [63:0] sqt;
  always_comb sqt = res + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ns <= N_IDLE; sts <= '0; degen <= 1'b0;
      nx <= '0; ny <= '0; nz <= '0;
    end else begin
      sts.norm_done <= 1'b0;
      unique case (ns)
        // closing pair lands in the sums during N_CWAIT
        N_IDLE: if (cmd.norm_start) ns <= N_CWAIT;
        N_CWAIT: ns <= N_ABS;
        N_ABS: begin
          negx <= sx[SUM_BITS-1]; negy <= sy[SUM_BITS-1]; negz <= sz[SUM_BITS-1];
          ax <= sx[SUM_BITS-1] ? SUM_BITS'(-sx) : sx;
          ay <= sy[SUM_BITS-1] ? SUM_BITS'(-sy) : sy;
          az <= sz[SUM_BITS-1] ? SUM_BITS'(-sz) : sz;
          ns <= N_SHIFT;
        end
        N_SHIFT: begin
          if (amax == '0) begin
            degen <= 1'b1; nx <= '0; ny <= '0; nz <= '0; ns <= N_DONE;
          end else if (amax >= (SUM_BITS'(1) << 31)) begin
            ax <= ax >> 1; ay <= ay >> 1; az <= az >> 1;
          end else if (amax < (SUM_BITS'(1) << 30)) begin
            ax <= ax << 1; ay <= ay << 1; az <= az << 1;
          end else begin
            degen <= 1'b0; l2 <= '0; ns <= N_SQ0;
          end
        end
        N_SQ0: begin l2 <= sq; ns <= N_SQ1; end
        N_SQ1: begin l2 <= l2 + sq; ns <= N_SQ2; end
        N_SQ2: begin
          l2 <= l2 + sq;
          res <= '0; bitv <= 64'd1 << 62; ns <= N_SQRT;
        end
        N_SQRT: begin
          if (bitv == '0) begin
            len <= (res == '0) ? 32'd1 : res[31:0];
            di <= 2'd0; qc <= '0;
            ns <= N_DIV;
          end else if (l2 >= sqt) begin
            l2 <= l2 - sqt; res <= (res >> 1) + bitv; bitv <= bitv >> 2;
          end else begin
            res <= res >> 1; bitv <= bitv >> 2;
          end
        end
        N_DIV: begin
          ns <= N_DIV;
          if (qc == 6'd0) begin
            // numerator a*16384 + len/2 (fits 47 bits)
            num <= 47'({dval[31:0], 14'd0}) + 47'(len >> 1);
            r <= '0; q <= '0; qc <= 6'd1;
          end else if (qc <= 6'd47) begin
            if ({r[46:0], num[46]} >= {16'd0, len}) begin
              r <= {r[46:0], num[46]} - {16'd0, len}; q <= {q[45:0], 1'b1};
            end else begin
              r <= {r[46:0], num[46]}; q <= {q[45:0], 1'b0};
            end
            num <= num << 1; qc <= qc + 6'd1;
          end else begin
            unique case (di)
              2'd0: nx <= negx ? -qm : qm;
              2'd1: ny <= negy ? -qm : qm;
              default: nz <= negz ? -qm : qm;
            endcase
            qc <= '0;
            if (di == 2'd2) ns <= N_DONE; else di <= di + 2'd1;
          end
        end
        N_DONE: begin sts.norm_done <= 1'b1; ns <= N_IDLE; end
        default: ns <= N_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### hw/rtl/polygon_normal_newell_core.sv
`default_nettype none
// Newell polygon normal. Vertices stream in on s_axis, one item per vertex,
// tlast on the final vertex of each polygon. Each vertex item is registered,
// then one multiply/accumulate of the pair is run; s_axis_tready is low while
// the pair is multiplied. On the last vertex the closing pair is added and the
// sum vector is normalized by a shared sequencer: shift to range, three
// squares, a 32-step square root and three 47-step restoring divides.
// The result is loaded into the output register when normalization is done;
// a zero sum skips the squares, root and divides. Input stays stalled until
// the result is loaded, so a held result on m_axis also holds off the next
// polygon. One result item per polygon comes out on m_axis; degenerate (zero)
// sums give a zero vector with tuser=1.
module polygon_normal_newell_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // vertex_x, vertex_y, vertex_z
  input  wire logic        s_axis_tlast,  // last_vertex
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // normal_x, normal_y, normal_z
  output logic             m_axis_tuser   // degenerate
);
  import pnn_pkg::*;
  pnn_cmd_t cmd;
  pnn_sts_t sts;
  logic res_load, in_fire, dg;
  logic signed [OUT_BITS-1:0] nx, ny, nz;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  pnn_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_axis_tlast),
    .out_busy(m_axis_tvalid && !m_axis_tready),
    .sts, .in_ready(s_axis_tready), .cmd, .res_load
  );

  pnn_dp u_dp (
    .clk, .rst, .cmd,
    .in_x(s_axis_tdata[23:0]), .in_y(s_axis_tdata[47:24]), .in_z(s_axis_tdata[71:48]),
    .sts, .nx, .ny, .nz, .degen(dg)
  );

  // output register; reloads only when empty or being drained this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
      m_axis_tdata  <= {nz, ny, nx};
      m_axis_tuser  <= dg;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/pnn_checker.sv
`default_nettype none
module pnn_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic m_axis_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("degenerate result not zero");
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");
endmodule
bind polygon_normal_newell_core pnn_checker u_chk (.*);
`default_nettype wire

### sim/polygon_normal_newell_core_tb.sv
`default_nettype none
module polygon_normal_newell_core_tb;
  import pnn_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0] wsum_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] nx;
    logic [OUT_BITS-1:0] ny;
    logic [OUT_BITS-1:0] nz;
    logic                degen;
  } normal_t;

  typedef struct {
    coord_t x, y, z;
    logic   last;
    logic   has_known;  // row carries a hand-typed result
    normal_t known;
  } vrow_t;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int TAIL_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // vertex_x, vertex_y, vertex_z
  logic s_axis_tlast = 1'b0;       // last_vertex
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // normal_x, normal_y, normal_z
  logic m_axis_tuser;              // degenerate

  always #2 clk = ~clk;

  polygon_normal_newell_core i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // ---------------- normal predictor ----------------
  coord_t first_v[3], prev_v[3];
  wsum_t  acc[3];
  logic   in_poly = 1'b0;
  normal_t pending_normals[$];
  int errors = 0;
  int cycles = 0;
  bit long_hold = 0;

  function automatic wsum_t prod_sat(longint p, longint q);
    logic [127:0] m;
    logic [127:0] lim;
    lim = SUM_LIM;
    m = (p < 0 ? -p : p) * (q < 0 ? -q : q);
    if (m > lim) m = lim;
    return ((p < 0) != (q < 0)) ? -wsum_t'(m) : wsum_t'(m);
  endfunction

  task automatic add_edge(coord_t a[3], coord_t b[3]);
    acc[0] = sat_add(acc[0], prod_sat(longint'(a[1]) - b[1], longint'(a[2]) + b[2]));
    acc[1] = sat_add(acc[1], prod_sat(longint'(a[2]) - b[2], longint'(a[0]) + b[0]));
    acc[2] = sat_add(acc[2], prod_sat(longint'(a[0]) - b[0], longint'(a[1]) + b[1]));
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal();
    normal_t res;
    longint unsigned a[3], mx, l2, len, n;
    logic [OUT_BITS-1:0] o[3];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = acc[i] < 0 ? -acc[i] : acc[i];
      if (a[i] > mx) mx = a[i];
    end
    if (mx == 0) return '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
    while (mx >= (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) a[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) a[i] <<= 1;
    end
    l2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    len = int_sqrt(l2);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      n = (a[i] * OUT_ONE + (len >> 1)) / len;
      if (n > OUT_ONE) n = OUT_ONE;
      o[i] = acc[i] < 0 ? -n[OUT_BITS-1:0] : n[OUT_BITS-1:0];
    end
    return '{nx: o[0], ny: o[1], nz: o[2], degen: 1'b0};
  endfunction

  // one accepted vertex; queues a normal on the closing vertex
  task automatic take_vertex(vrow_t r);
    coord_t v[3];
    normal_t nrm;
    v = '{r.x, r.y, r.z};
    if (!in_poly) begin
      first_v = v;
      prev_v = v;
      acc = '{default: '0};
      in_poly = 1'b1;
    end else begin
      add_edge(prev_v, v);
      prev_v = v;
    end
    if (r.last) begin
      add_edge(prev_v, first_v);
      nrm = unit_normal();
      if (r.has_known && nrm != r.known) begin
        errors++;
        if (errors <= 10)
          $display("table row disagrees with predictor: %h vs %h", r.known, nrm);
      end
      pending_normals.insert(pending_normals.size(), nrm);
      in_poly = 1'b0;
    end
  endtask

  // ---------------- result checking ----------------
  always @(posedge clk) begin
    normal_t got, want;
    cycles <= cycles + 1;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser};
      if (pending_normals.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected normal %h", got);
      end else begin
        want = pending_normals.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("normal mismatch: exp x=%h y=%h z=%h deg=%b got x=%h y=%h z=%h deg=%b",
                     want.nx, want.ny, want.nz, want.degen,
                     got.nx, got.ny, got.nz, got.degen);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: own stall pattern, plus one long hold-off
  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(negedge clk);
        long_hold = 0;
      end
      case ($urandom_range(0, 3))
        0: m_axis_tready <= 1'b0;
        1: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready <= 1'b1;
      endcase
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // ---------------- stimulus ----------------
  vrow_t dir_rows[$];
  int    burst_left = 0;

  function automatic void add_row(vrow_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  task automatic send_vertex(vrow_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.z, r.y, r.x};
    s_axis_tlast <= r.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    take_vertex(r);
    @(negedge clk);
  endtask

  function automatic vrow_t mk(int x, int y, int z, bit last);
    return '{x: coord_t'(x), y: coord_t'(y), z: coord_t'(z), last: last,
             has_known: 0, known: '0};
  endfunction

  function automatic vrow_t mkk(int x, int y, int z, bit last, normal_t k);
    return '{x: coord_t'(x), y: coord_t'(y), z: coord_t'(z), last: last,
             has_known: 1, known: k};
  endfunction

  function automatic coord_t rnd_coord(int spread);
    case (spread)
      0: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
      1: return coord_t'($urandom);
      default: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_normals.size() != 0) @(negedge clk);
  endtask

  localparam normal_t ZERO_DEG = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
  localparam normal_t PLUS_Z   = '{nx: '0, ny: '0, nz: 16'd16384, degen: 1'b0};
  localparam normal_t MINUS_Z  = '{nx: '0, ny: '0, nz: 16'hC000, degen: 1'b0};

  initial begin
    int total, nverts, spread;
    vrow_t r;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single vertex, collinear, a square and a triangle in opposite windings, extremes, a tiny triangle
    add_row(mkk(0, 0, 0, 1, ZERO_DEG));
    add_row(mkk(8388607, -8388608, 12345, 1, ZERO_DEG));
    add_row(mk(0, 0, 0, 0));
    add_row(mk(4096, 4096, 4096, 0));
    add_row(mkk(8192, 8192, 8192, 1, ZERO_DEG));
    add_row(mk(0, 0, 0, 0));
    add_row(mk(4096, 0, 0, 0));
    add_row(mk(4096, 4096, 0, 0));
    add_row(mkk(0, 4096, 0, 1, PLUS_Z));
    add_row(mk(0, 0, 0, 0));
    add_row(mk(0, 4096, 0, 0));
    add_row(mkk(4096, 0, 0, 1, MINUS_Z));
    add_row(mk(-8388608, -8388608, -8388608, 0));
    add_row(mk(8388607, -8388608, 8388607, 0));
    add_row(mk(8388607, 8388607, -8388608, 1));
    add_row(mk(-8388608, 8388607, 8388607, 0));
    add_row(mk(8388607, -8388608, -8388608, 0));
    add_row(mk(-8388608, -8388608, 8388607, 0));
    add_row(mk(8388607, 8388607, 8388607, 1));
    add_row(mk(1, 0, 0, 0));
    add_row(mk(0, 1, 0, 0));
    add_row(mk(0, 0, 1, 1));
    foreach (dir_rows[i]) send_vertex(dir_rows[i]);
    total = dir_rows.size();

    // sender pause until everything has drained
    wait_drained();

    // long receiver hold-off while the sender keeps going
    long_hold = 1;
    for (int p = 0; p < 30; p++) begin
      nverts = $urandom_range(1, 6);
      for (int k = 0; k < nverts; k++)
        send_vertex(mk($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535), k == nverts - 1));
      total += nverts;
    end

    // random polygons; mostly small, a few long ones
    while (total < 1050) begin
      spread = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 4) == 0 ? 2 : 1);
      nverts = $urandom_range(0, 40) == 0 ? $urandom_range(200, 300) : $urandom_range(1, 8);
      if (nverts > 1050 - total) nverts = 1050 - total;
      for (int k = 0; k < nverts; k++) begin
        r = mk(0, 0, 0, k == nverts - 1);
        r.x = rnd_coord(spread);
        r.y = rnd_coord(spread);
        r.z = rnd_coord(spread);
        send_vertex(r);
      end
      total += nverts;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
